// ----- rtl/slp_pkg.sv -----
package slp_pkg;

    // Lexer states, one-hot
    typedef enum logic [6:0] {
        ST_BEGIN   = 7'b0000001,
        ST_NAME    = 7'b0000010,
        ST_BETWEEN = 7'b0000100,
        ST_VALUE   = 7'b0001000,
        ST_QVALUE  = 7'b0010000,
        ST_COMMENT = 7'b0100000,
        ST_QFIRST  = 7'b1000000
    } t_lex_state;

    // Byte roles
    typedef logic [1:0] t_role;
    localparam t_role ROLE_SKIP  = 2'd0;
    localparam t_role ROLE_NAME  = 2'd1;
    localparam t_role ROLE_VALUE = 2'd2;

    // Error codes
    typedef logic [1:0] t_err;
    localparam t_err ERR_NONE  = 2'd0;
    localparam t_err ERR_EMPTY = 2'd1;
    localparam t_err ERR_QUOTE = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;

endpackage

// ----- rtl/spec_line_lexer.sv -----
// Byte-wise lexer for spec lines "name blanks value". Every accepted input beat
// yields exactly one tagged output beat in the next cycle; a new byte is taken in
// every cycle as long as the output beat is being taken or the output register
// is empty, so the sustained rate is one byte per clock, set by the single
// state register and the output register behind it. Assert i_start_of_file on
// the first byte of each file to clear lexer state and the sticky error, and
// feed one zero byte after the last byte of the file so a final entry commits.
// o_field_count is 1 plus the dots in the committed name, saturating at
// MAX_FIELDS and truncated to 5 bits; it is zero on beats without o_entry_done.
module spec_line_lexer #(
    parameter int MAX_FIELDS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_start_of_file,
    input  logic [7:0]          i_in_byte,
    // output channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output slp_pkg::t_role      o_role,
    output logic                o_is_dot,
    output logic                o_name_begin,
    output logic                o_value_begin,
    output logic                o_entry_done,
    output logic [4:0]          o_field_count,
    output slp_pkg::t_err       o_error_code,
    output logic                o_error_seen
);
    import slp_pkg::*;

    localparam int TW = $clog2(MAX_FIELDS + 1);
    localparam logic [TW-1:0] TALLY_MAX = TW'(MAX_FIELDS);
    localparam logic [TW-1:0] TALLY_ONE = TW'(1);

    // lexer state
    t_lex_state    r_state, n_state;
    logic          r_esc, n_esc;
    logic          r_closed, n_closed;
    logic [TW-1:0] r_tally, n_tally;
    logic          r_err_flag, n_err_flag;

    // output register
    logic          r_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    t_role         r_role, n_role;
    logic          r_is_dot, n_is_dot;
    logic          r_nb, n_nb;
    logic          r_vb, n_vb;
    logic          r_done, n_done;
    logic [4:0]    r_count, n_count;
    t_err          r_err, n_err;

    logic          accept;
    logic [7:0]    c;
    logic          blank;
    t_lex_state    cur_state;
    logic          cur_esc, cur_closed, cur_err_flag;
    logic [TW-1:0] cur_tally;
    logic [TW+4:0] tally_ext;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign c       = i_in_byte;
    assign blank   = (c == CH_SPACE) || (c == CH_TAB);

    // start of file restarts from the reset state
    assign cur_state    = i_start_of_file ? ST_BEGIN  : r_state;
    assign cur_esc      = i_start_of_file ? 1'b0      : r_esc;
    assign cur_closed   = i_start_of_file ? 1'b0      : r_closed;
    assign cur_tally    = i_start_of_file ? TALLY_ONE : r_tally;
    assign cur_err_flag = i_start_of_file ? 1'b0      : r_err_flag;
    assign tally_ext    = {5'd0, cur_tally};

    // next state and tags for one byte
    always_comb begin
        n_state    = cur_state;
        n_esc      = cur_esc;
        n_closed   = cur_closed;
        n_tally    = cur_tally;
        n_out_byte = c;
        n_role     = ROLE_SKIP;
        n_is_dot   = 1'b0;
        n_nb       = 1'b0;
        n_vb       = 1'b0;
        n_done     = 1'b0;
        n_count    = 5'd0;
        n_err      = ERR_NONE;

        case (cur_state)
            ST_NAME: begin
                if (blank || c == CH_NUL) begin
                    n_state = ST_BETWEEN;
                end else if (c == CH_LF) begin
                    n_err   = ERR_EMPTY;
                    n_state = ST_BEGIN;
                end else if (c == CH_HASH) begin
                    n_err   = ERR_EMPTY;
                    n_state = ST_COMMENT;
                end else begin
                    n_role = ROLE_NAME;
                    if (c == CH_DOT) begin
                        n_is_dot = 1'b1;
                        if (cur_tally < TALLY_MAX) begin
                            n_tally = cur_tally + TALLY_ONE;
                        end
                    end
                end
            end
            ST_BETWEEN: begin
                if (blank || c == CH_NUL) begin
                    n_state = ST_BETWEEN;
                end else if (c == CH_LF) begin
                    n_err   = ERR_EMPTY;
                    n_state = ST_BEGIN;
                end else if (c == CH_HASH) begin
                    n_err   = ERR_EMPTY;
                    n_state = ST_COMMENT;
                end else if (c == CH_QUOTE) begin
                    n_state  = ST_QFIRST;
                    n_esc    = 1'b0;
                    n_closed = 1'b0;
                end else begin
                    n_role   = ROLE_VALUE;
                    n_vb     = 1'b1;
                    n_closed = 1'b0;
                    n_state  = ST_VALUE;
                end
            end
            ST_VALUE: begin
                if (blank) begin
                    n_closed = 1'b1;
                end else if (c == CH_NUL || c == CH_LF || c == CH_HASH) begin
                    n_done  = 1'b1;
                    n_count = tally_ext[4:0];
                    n_state = (c == CH_HASH) ? ST_COMMENT : ST_BEGIN;
                end else if (!cur_closed) begin
                    n_role = ROLE_VALUE;
                end
            end
            ST_QVALUE, ST_QFIRST: begin
                if (cur_esc) begin
                    // escaped byte is taken literally
                    n_esc  = 1'b0;
                    n_role = ROLE_VALUE;
                end else if (c == CH_BSL) begin
                    n_out_byte = CH_SPACE;
                    n_role     = ROLE_VALUE;
                    n_vb       = (cur_state == ST_QFIRST);
                    n_esc      = 1'b1;
                    n_state    = ST_QVALUE;
                end else if (c == CH_LF || c == CH_HASH) begin
                    // unended quote: at a newline the next line is swallowed, at '#' the rest of this line
                    n_err   = ERR_QUOTE;
                    n_state = ST_COMMENT;
                end else if (c == CH_QUOTE) begin
                    n_closed = 1'b1;
                    n_state  = ST_VALUE;
                end else begin
                    n_role  = ROLE_VALUE;
                    n_vb    = (cur_state == ST_QFIRST);
                    n_state = ST_QVALUE;
                end
            end
            ST_COMMENT: begin
                if (c == CH_LF) begin
                    n_state = ST_BEGIN;
                end
            end
            default: begin
                // begin of line
                if (blank || c == CH_NUL || c == CH_LF) begin
                    n_state = ST_BEGIN;
                end else if (c == CH_HASH) begin
                    n_state = ST_COMMENT;
                end else begin
                    n_role  = ROLE_NAME;
                    n_nb    = 1'b1;
                    n_tally = (c == CH_DOT) ? TALLY_ONE + TALLY_ONE : TALLY_ONE;
                    n_state = ST_NAME;
                end
            end
        endcase

        n_err_flag = cur_err_flag || (n_err != ERR_NONE);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_BEGIN;
            r_esc      <= 1'b0;
            r_closed   <= 1'b0;
            r_tally    <= TALLY_ONE;
            r_err_flag <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_state    <= n_state;
                r_esc      <= n_esc;
                r_closed   <= n_closed;
                r_tally    <= n_tally;
                r_err_flag <= n_err_flag;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte <= n_out_byte;
            r_role     <= n_role;
            r_is_dot   <= n_is_dot;
            r_nb       <= n_nb;
            r_vb       <= n_vb;
            r_done     <= n_done;
            r_count    <= n_count;
            r_err      <= n_err;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_out_byte;
    assign o_role        = r_role;
    assign o_is_dot      = r_is_dot;
    assign o_name_begin  = r_nb;
    assign o_value_begin = r_vb;
    assign o_entry_done  = r_done;
    assign o_field_count = r_count;
    assign o_error_code  = r_err;
    assign o_error_seen  = r_err_flag;

    // checks
    a_count_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_done |-> o_field_count == 5'd0)
        else $error("field count without committed entry");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |-> o_error_seen)
        else $error("error raised but not sticky");

    a_name_begin_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_name_begin |-> o_role == ROLE_NAME && !o_value_begin)
        else $error("name begin on non-name byte");

    a_dot_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_dot |-> o_role == ROLE_NAME && o_out_byte == CH_DOT)
        else $error("dot flag on wrong byte");

endmodule

// ----- tb/tb_spec_line_lexer.sv -----
`timescale 1ns / 100ps

module tb_spec_line_lexer;
    import slp_pkg::*;

    localparam int FIELD_CAP   = 16;     // matches the block's default MAX_FIELDS
    localparam int QUIET_LIMIT = 2000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off

    // One tagged output beat
    typedef struct packed {
        logic [7:0] out_byte;
        t_role      role;
        logic       is_dot;
        logic       name_begin;
        logic       value_begin;
        logic       entry_done;
        logic [4:0] field_count;
        t_err       error_code;
        logic       error_seen;
    } t_lex_beat;

    // One input beat
    typedef struct {
        bit         sof;
        logic [7:0] b;
    } t_text_beat;

    // Lexer predictor plus queue of tagged bytes still to come out
    class t_lexer_scoreboard;
        t_lex_state  state;
        bit          esc_pending;
        bit          value_ended;
        int unsigned dot_count;
        bit          err_sticky;
        t_lex_beat   expected_q[$];
        int          faults;

        function new();
            faults = 0;
            clear_lexer();
        endfunction

        function void clear_lexer();
            state       = ST_BEGIN;
            esc_pending = 1'b0;
            value_ended = 1'b0;
            dot_count   = 1;
            err_sticky  = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string show(t_lex_beat t);
            return {$sformatf("byte=%02h role=%0d dot=%0b nb=%0b vb=%0b ",
                              t.out_byte, t.role, t.is_dot, t.name_begin, t.value_begin),
                    $sformatf("done=%0b cnt=%0d err=%0d seen=%0b",
                              t.entry_done, t.field_count, t.error_code, t.error_seen)};
        endfunction

        function void report(string what);
            faults++;
            if (faults <= 10)
                $display("lexer mismatch at %0t: %s", $realtime, what);
        endfunction

        // Tag one accepted input byte and queue the tagged beat it yields
        function void note_input(bit sof, logic [7:0] c);
            t_lex_beat e;
            bit        blank;
            e = '0;
            e.out_byte = c;
            e.role = ROLE_SKIP;
            e.error_code = ERR_NONE;
            if (sof)
                clear_lexer();
            blank = (c == CH_SPACE) || (c == CH_TAB);
            case (state)
                ST_NAME: begin
                    if (blank || c == CH_NUL) begin
                        state = ST_BETWEEN;
                    end else if (c == CH_LF) begin
                        e.error_code = ERR_EMPTY;
                        state = ST_BEGIN;
                    end else if (c == CH_HASH) begin
                        e.error_code = ERR_EMPTY;
                        state = ST_COMMENT;
                    end else begin
                        e.role = ROLE_NAME;
                        if (c == CH_DOT) begin
                            e.is_dot = 1'b1;
                            if (dot_count < FIELD_CAP)
                                dot_count++;
                        end
                    end
                end
                ST_BETWEEN: begin
                    if (blank || c == CH_NUL) begin
                        // stay
                    end else if (c == CH_LF) begin
                        e.error_code = ERR_EMPTY;
                        state = ST_BEGIN;
                    end else if (c == CH_HASH) begin
                        e.error_code = ERR_EMPTY;
                        state = ST_COMMENT;
                    end else if (c == CH_QUOTE) begin
                        state = ST_QFIRST;
                        esc_pending = 1'b0;
                        value_ended = 1'b0;
                    end else begin
                        e.role = ROLE_VALUE;
                        e.value_begin = 1'b1;
                        value_ended = 1'b0;
                        state = ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    if (blank) begin
                        value_ended = 1'b1;
                    end else if (c == CH_NUL || c == CH_LF || c == CH_HASH) begin
                        e.entry_done = 1'b1;
                        e.field_count = dot_count[4:0];
                        state = (c == CH_HASH) ? ST_COMMENT : ST_BEGIN;
                    end else if (!value_ended) begin
                        e.role = ROLE_VALUE;
                    end
                end
                ST_QVALUE, ST_QFIRST: begin
                    if (esc_pending) begin
                        // escaped byte is taken literally
                        esc_pending = 1'b0;
                        e.role = ROLE_VALUE;
                    end else if (c == CH_BSL) begin
                        e.out_byte = CH_SPACE;
                        e.role = ROLE_VALUE;
                        e.value_begin = (state == ST_QFIRST);
                        esc_pending = 1'b1;
                        state = ST_QVALUE;
                    end else if (c == CH_LF || c == CH_HASH) begin
                        // unended quote at a newline also swallows the following line
                        e.error_code = ERR_QUOTE;
                        state = ST_COMMENT;
                    end else if (c == CH_QUOTE) begin
                        value_ended = 1'b1;
                        state = ST_VALUE;
                    end else begin
                        e.role = ROLE_VALUE;
                        e.value_begin = (state == ST_QFIRST);
                        state = ST_QVALUE;
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_LF)
                        state = ST_BEGIN;
                end
                default: begin
                    if (blank || c == CH_NUL || c == CH_LF) begin
                        state = ST_BEGIN;
                    end else if (c == CH_HASH) begin
                        state = ST_COMMENT;
                    end else begin
                        // leading dot counts but is not flagged
                        e.role = ROLE_NAME;
                        e.name_begin = 1'b1;
                        dot_count = 1;
                        if (c == CH_DOT && dot_count < FIELD_CAP)
                            dot_count++;
                        state = ST_NAME;
                    end
                end
            endcase
            if (e.error_code != ERR_NONE)
                err_sticky = 1'b1;
            e.error_seen = err_sticky;
            expected_q.push_back(e);
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_result(t_lex_beat got);
            t_lex_beat want;
            if (expected_q.size() == 0) begin
                report({"unexpected beat ", show(got)});
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.role !== want.role ||
                got.is_dot !== want.is_dot || got.name_begin !== want.name_begin ||
                got.value_begin !== want.value_begin || got.entry_done !== want.entry_done ||
                got.field_count !== want.field_count || got.error_code !== want.error_code ||
                got.error_seen !== want.error_seen)
                report({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

    // DUT signals
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_start_of_file = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    t_role      o_role;
    logic       o_is_dot;
    logic       o_name_begin;
    logic       o_value_begin;
    logic       o_entry_done;
    logic [4:0] o_field_count;
    t_err       o_error_code;
    logic       o_error_seen;

    t_lexer_scoreboard sb;
    t_text_beat        stim_q[$];
    bit                next_sof;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                hold_left = 0;
    int                quiet_cycles = 0;

    // Directed text: blank and zero at line begin, leading dot, escaped quote,
    // junk after a closed value, name cut by newline, unended quote that eats
    // the next line, final zero byte
    logic [7:0] directed_text [25] = '{
        CH_NUL, CH_TAB, CH_DOT, "a", CH_DOT, "b", CH_SPACE, CH_QUOTE, CH_BSL, CH_QUOTE,
        CH_QUOTE, CH_SPACE, "z", CH_LF, "k", CH_LF, "k", CH_SPACE, CH_QUOTE, CH_LF,
        "x", CH_SPACE, "y", CH_LF, CH_NUL
    };

    spec_line_lexer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_of_file (i_start_of_file),
        .i_in_byte       (i_in_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_role          (o_role),
        .o_is_dot        (o_is_dot),
        .o_name_begin    (o_name_begin),
        .o_value_begin   (o_value_begin),
        .o_entry_done    (o_entry_done),
        .o_field_count   (o_field_count),
        .o_error_code    (o_error_code),
        .o_error_seen    (o_error_seen)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Beat monitor and watchdog
    always @(posedge i_clk) begin
        t_lex_beat got;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && o_ready) begin
                sb.note_input(i_start_of_file, i_in_byte);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                got.out_byte    = o_out_byte;
                got.role        = o_role;
                got.is_dot      = o_is_dot;
                got.name_begin  = o_name_begin;
                got.value_begin = o_value_begin;
                got.entry_done  = o_entry_done;
                got.field_count = o_field_count;
                got.error_code  = o_error_code;
                got.error_seen  = o_error_seen;
                sb.check_result(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Text generation
    function void put(logic [7:0] b);
        stim_q.push_back('{next_sof, b});
        next_sof = 1'b0;
    endfunction

    function void put_blanks(int unsigned lo, int unsigned hi);
        int unsigned n;
        n = $urandom_range(hi, lo);
        repeat (n) put($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
    endfunction

    // Printable or high byte that is not a blank, '#', quote or backslash
    function logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(99, 0) < 70)
            return 8'h61 + 8'($urandom_range(25, 0));
        do
            c = 8'($urandom_range(255, 33));
        while (c == CH_HASH || c == CH_QUOTE || c == CH_BSL);
        return c;
    endfunction

    // Dotted name, sometimes with a leading dot or enough dots to saturate
    function void put_name();
        int unsigned fields;
        if ($urandom_range(99, 0) < 10)
            fields = $urandom_range(24, 14);
        else
            fields = $urandom_range(4, 1);
        if ($urandom_range(99, 0) < 10)
            put(CH_DOT);
        for (int unsigned f = 0; f < fields; f++) begin
            if (f != 0)
                put(CH_DOT);
            repeat ($urandom_range(3, 1)) put(text_char());
        end
    endfunction

    function void put_value();
        if ($urandom_range(99, 0) < 55) begin
            repeat ($urandom_range(6, 1)) put(text_char());
        end else begin
            put(CH_QUOTE);
            repeat ($urandom_range(6, 0)) begin
                case ($urandom_range(19, 0))
                    0, 1, 2: begin
                        put(CH_BSL);
                        put(8'($urandom_range(255, 0)));
                    end
                    3:       put(CH_NUL);
                    default: put(text_char());
                endcase
            end
            // mostly closed, sometimes junk after the closing quote
            if ($urandom_range(99, 0) < 85) begin
                put(CH_QUOTE);
                if ($urandom_range(99, 0) < 20)
                    repeat ($urandom_range(3, 1)) put(text_char());
            end
        end
    endfunction

    function void put_line_end();
        case ($urandom_range(6, 0))
            0: begin
                put_blanks(1, 3);
                put(CH_LF);
            end
            1: begin
                put(CH_HASH);
                repeat ($urandom_range(5, 0)) put(8'($urandom_range(255, 11)));
                put(CH_LF);
            end
            default: put(CH_LF);
        endcase
    endfunction

    function void put_line();
        int unsigned kind;
        kind = $urandom_range(99, 0);
        if ($urandom_range(99, 0) < 30)
            put_blanks(1, 2);
        if (kind < 65) begin
            // well-formed entry
            put_name();
            put_blanks(1, 3);
            put_value();
            put_line_end();
        end else if (kind < 72) begin
            if (kind[0])
                put(CH_HASH);
            put_line_end();
        end else if (kind < 80) begin
            // name with no value
            put_name();
            put(kind[0] ? CH_HASH : CH_LF);
            put(CH_LF);
        end else if (kind < 86) begin
            put_name();
            put_blanks(1, 2);
            put(kind[0] ? CH_HASH : CH_LF);
            put(CH_LF);
        end else begin
            // raw noise
            repeat ($urandom_range(12, 1)) put(8'($urandom_range(255, 0)));
            put(CH_LF);
        end
    endfunction

    // Whole file: start flag on the first byte, closing zero byte mostly
    function void put_file();
        next_sof = 1'b1;
        repeat ($urandom_range(8, 1)) put_line();
        if ($urandom_range(99, 0) < 30) begin
            put_name();
            put_blanks(1, 2);
            put_value();
        end
        if ($urandom_range(99, 0) < 90)
            put(CH_NUL);
    endfunction

    // Offer one input beat; entered and left at a falling edge
    task automatic drive_beat(bit sof, logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_of_file <= sof;
        i_in_byte <= b;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    // Send the queued text, then wait until every tagged byte is back
    task automatic run_phase(int idle_pct, int stall, int hold_at);
        int n;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        n = 0;
        while (stim_q.size() != 0) begin
            if (n == hold_at)
                hold_left = HOLD_CYCLES;
            drive_beat(stim_q[0].sof, stim_q[0].b);
            void'(stim_q.pop_front());
            n++;
        end
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed text
        next_sof = 1'b1;
        foreach (directed_text[k])
            put(directed_text[k]);
        run_phase(0, 0, -1);

        // random files under each idling pattern
        while (stim_q.size() < 400) put_file();
        run_phase(0, 0, 100);
        while (stim_q.size() < 400) put_file();
        run_phase(86, 0, -1);
        while (stim_q.size() < 400) put_file();
        run_phase(0, 86, -1);
        while (stim_q.size() < 400) put_file();
        run_phase(19, 19, -1);

        repeat (8) @(posedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/slp_pkg.sv
rtl/spec_line_lexer.sv
tb/tb_spec_line_lexer.sv
